>>> sv/tgad_pkg.sv
`timescale 1ns / 1ps

package tgad_pkg;

  // decoder phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_SKIP   = 3'b010,
    PH_PIXELS = 3'b100
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_PIXEL   = 2'd0;
  localparam logic [1:0] KIND_HDR_OK  = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;

  // rejection codes
  localparam logic [1:0] ERR_NOT_TYPE2 = 2'd0;
  localparam logic [1:0] ERR_BAD_DEPTH = 2'd1;
  localparam logic [1:0] ERR_COLOR_MAP = 2'd2;

  // header byte offsets
  localparam logic [4:0] HDR_ID_LEN     = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
  localparam logic [4:0] HDR_DEPTH      = 5'd16;
  localparam logic [4:0] HDR_LAST       = 5'd17;

  localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
  localparam logic [7:0] DEPTH_16 = 8'd16;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // bytes per pixel codes (depth / 8)
  localparam logic [4:0] BPP_2 = 5'd2;
  localparam logic [4:0] BPP_3 = 5'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  error_code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  pixel_depth;
    logic        has_alpha;
    logic        last;
  } res_t;

endpackage

>>> sv/tgad_out_buf.sv
`timescale 1ns / 1ps

module tgad_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  tgad_pkg::res_t  wr_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tgad_pkg::res_t  out_data
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  tgad_pkg::res_t main_r, main_nxt;
  tgad_pkg::res_t skid_r, skid_nxt;
  logic           pop;

  assign wr_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign pop       = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (wr_valid) begin
      if (!main_valid_r || pop) begin
        main_nxt       = wr_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = wr_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> sv/tga_truecolor_stream_decoder.sv
`timescale 1ns / 1ps
// a byte that ends a header or pixel registers its item in the result or skid register
// throughput: one byte per cycle if in_ready; single decode step from state to result regs
// the two-entry result buffer keeps input flowing while one item waits on out_ready
// reset (rst_n low, synchronous): header phase, all counters and header fields cleared,
// result buffer empty

module tga_truecolor_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [7:0]  out_pixel_depth,
  output logic        out_has_alpha,
  output logic        out_last
);

  // decoder state
  tgad_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  id_len_r, id_len_nxt;
  logic [7:0]  cmap_type_r, cmap_type_nxt;
  logic [7:0]  img_type_r, img_type_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [31:0] pix_rem_r, pix_rem_nxt;
  logic [1:0]  pix_idx_r, pix_idx_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  held2_r, held2_nxt;

  logic           in_acc;
  logic           res_valid;
  tgad_pkg::res_t res;
  tgad_pkg::res_t out_data;
  logic [4:0]     nbytes;
  logic           in_skip;
  logic           in_pixels;
  logic           depth_ok;

  assign in_acc    = in_valid && in_ready;
  assign nbytes    = depth_r[7:3];
  assign in_skip   = (phase_r == tgad_pkg::PH_SKIP);
  // a pixel phase with nothing left falls back to header decoding
  assign in_pixels = (phase_r == tgad_pkg::PH_PIXELS) && (pix_rem_r != 32'd0);
  assign depth_ok  = (depth_r == tgad_pkg::DEPTH_16) || (depth_r == tgad_pkg::DEPTH_24)
                  || (depth_r == tgad_pkg::DEPTH_32);

  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    id_len_nxt    = id_len_r;
    cmap_type_nxt = cmap_type_r;
    img_type_nxt  = img_type_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    depth_nxt     = depth_r;
    skip_nxt      = skip_r;
    pix_rem_nxt   = pix_rem_r;
    pix_idx_nxt   = pix_idx_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    held2_nxt     = held2_r;

    res_valid        = 1'b0;
    res              = '0;
    // header values go out on every item; none are written on the byte that ends a
    // header or a pixel, so the current registers are the right ones
    res.image_width  = width_r;
    res.image_height = height_r;
    res.pixel_depth  = depth_r;
    res.has_alpha    = (depth_r == tgad_pkg::DEPTH_16) || (depth_r == tgad_pkg::DEPTH_32);

    if (in_acc) begin
      if (in_skip) begin
        // drop id field bytes
        skip_nxt = skip_r - 8'd1;
        if (skip_nxt == 8'd0) begin
          phase_nxt = (pix_rem_r != 32'd0) ? tgad_pkg::PH_PIXELS : tgad_pkg::PH_HEADER;
        end
      end else if (in_pixels) begin
        if (({3'b000, pix_idx_r} + 5'd1) < nbytes) begin
          // gather bytes of the pixel, low byte first
          unique case (pix_idx_r)
            2'd0: held0_nxt = in_data_byte;
            2'd1: held1_nxt = in_data_byte;
            2'd2: held2_nxt = in_data_byte;
            2'd3: held2_nxt = held2_r;
          endcase
          pix_idx_nxt = pix_idx_r + 2'd1;
        end else begin
          res_valid = 1'b1;
          res.kind  = tgad_pkg::KIND_PIXEL;
          if (nbytes == tgad_pkg::BPP_2) begin
            // 1-5-5-5: attribute bit, red, green split over both bytes, blue
            res.red   = {in_data_byte[6:2], 3'b000};
            res.green = {in_data_byte[1:0], held0_r[7:5], 3'b000};
            res.blue  = {held0_r[4:0], 3'b000};
            res.alpha = {in_data_byte[7], 7'b0000000};
          end else if (nbytes == tgad_pkg::BPP_3) begin
            // b, g, r with no alpha in the file
            res.red   = in_data_byte;
            res.green = held1_r;
            res.blue  = held0_r;
            res.alpha = 8'd0;
          end else begin
            // b, g, r, a
            res.red   = held2_r;
            res.green = held1_r;
            res.blue  = held0_r;
            res.alpha = in_data_byte;
          end
          pix_idx_nxt = 2'd0;
          held0_nxt   = 8'd0;
          held1_nxt   = 8'd0;
          held2_nxt   = 8'd0;
          pix_rem_nxt = pix_rem_r - 32'd1;
          res.last    = (pix_rem_r == 32'd1);
          if (res.last) begin
            phase_nxt = tgad_pkg::PH_HEADER;
          end
        end
      end else begin
        // header byte; also folds an unused phase code back to header
        phase_nxt = tgad_pkg::PH_HEADER;
        unique case (hdr_cnt_r)
          tgad_pkg::HDR_ID_LEN:    id_len_nxt    = in_data_byte;
          tgad_pkg::HDR_CMAP_TYPE: cmap_type_nxt = in_data_byte;
          tgad_pkg::HDR_IMG_TYPE:  img_type_nxt  = in_data_byte;
          tgad_pkg::HDR_WIDTH_LO:  width_nxt     = {width_r[15:8], in_data_byte};
          tgad_pkg::HDR_WIDTH_HI:  width_nxt     = {in_data_byte, width_r[7:0]};
          tgad_pkg::HDR_HEIGHT_LO: height_nxt    = {height_r[15:8], in_data_byte};
          tgad_pkg::HDR_HEIGHT_HI: height_nxt    = {in_data_byte, height_r[7:0]};
          tgad_pkg::HDR_DEPTH:     depth_nxt     = in_data_byte;
          default:                 depth_nxt     = depth_r;
        endcase
        if (hdr_cnt_r != tgad_pkg::HDR_LAST) begin
          hdr_cnt_nxt = hdr_cnt_r + 5'd1;
        end else begin
          hdr_cnt_nxt = 5'd0;
          res_valid   = 1'b1;
          // checks in order of priority: image type, then depth, then colour map
          priority if (img_type_r != tgad_pkg::IMG_TYPE_TRUECOLOR) begin
            res.kind       = tgad_pkg::KIND_HDR_BAD;
            res.error_code = tgad_pkg::ERR_NOT_TYPE2;
            res.last       = 1'b1;
          end else if (!depth_ok) begin
            res.kind       = tgad_pkg::KIND_HDR_BAD;
            res.error_code = tgad_pkg::ERR_BAD_DEPTH;
            res.last       = 1'b1;
          end else if (cmap_type_r != 8'd0) begin
            res.kind       = tgad_pkg::KIND_HDR_BAD;
            res.error_code = tgad_pkg::ERR_COLOR_MAP;
            res.last       = 1'b1;
          end else begin
            res.kind    = tgad_pkg::KIND_HDR_OK;
            res.last    = (width_r == 16'd0) || (height_r == 16'd0);
            // 16x16 product lands straight in the pixel counter
            pix_rem_nxt = {16'd0, width_r} * {16'd0, height_r};
            pix_idx_nxt = 2'd0;
            held0_nxt   = 8'd0;
            held1_nxt   = 8'd0;
            held2_nxt   = 8'd0;
            skip_nxt    = id_len_r;
            if (id_len_r != 8'd0) begin
              phase_nxt = tgad_pkg::PH_SKIP;
            end else if (!res.last) begin
              phase_nxt = tgad_pkg::PH_PIXELS;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tgad_pkg::PH_HEADER;
      hdr_cnt_r   <= 5'd0;
      id_len_r    <= 8'd0;
      cmap_type_r <= 8'd0;
      img_type_r  <= 8'd0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      depth_r     <= 8'd0;
      skip_r      <= 8'd0;
      pix_rem_r   <= 32'd0;
      pix_idx_r   <= 2'd0;
      held0_r     <= 8'd0;
      held1_r     <= 8'd0;
      held2_r     <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      id_len_r    <= id_len_nxt;
      cmap_type_r <= cmap_type_nxt;
      img_type_r  <= img_type_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      depth_r     <= depth_nxt;
      skip_r      <= skip_nxt;
      pix_rem_r   <= pix_rem_nxt;
      pix_idx_r   <= pix_idx_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
      held2_r     <= held2_nxt;
    end
  end

  // result register plus skid entry
  tgad_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (in_acc && res_valid),
    .wr_ready  (in_ready),
    .wr_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_error_code   = out_data.error_code;
  assign out_red          = out_data.red;
  assign out_green        = out_data.green;
  assign out_blue         = out_data.blue;
  assign out_alpha        = out_data.alpha;
  assign out_image_width  = out_data.image_width;
  assign out_image_height = out_data.image_height;
  assign out_pixel_depth  = out_data.pixel_depth;
  assign out_has_alpha    = out_data.has_alpha;
  assign out_last         = out_data.last;

  // header counter never runs past the last header byte
  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= tgad_pkg::HDR_LAST)
    else $error("header byte counter out of range");

  // pixel phase only follows a header with a supported depth, byte index below pixel size
  a_pixel_depth: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tgad_pkg::PH_PIXELS |-> depth_ok && ({3'b000, pix_idx_r} < nbytes))
    else $error("pixel phase with bad depth or byte index");

  // a rejected header sends the decoder back to the start of a header
  a_reject_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid && res.kind == tgad_pkg::KIND_HDR_BAD
      |=> phase_r == tgad_pkg::PH_HEADER && hdr_cnt_r == 5'd0)
    else $error("decoder did not restart after rejected header");

  // the last pixel of an image returns to header phase
  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid && res.kind == tgad_pkg::KIND_PIXEL && res.last
      |=> phase_r == tgad_pkg::PH_HEADER && pix_rem_r == 32'd0)
    else $error("decoder did not leave pixel phase after last pixel");

endmodule

>>> bench/tga_truecolor_stream_decoder_test.sv
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_test;

  // bytes in the whole run, directed files included
  localparam int N_BYTES     = 1650;
  // hang guard limit, set with a wide margin
  localparam int CYCLE_LIMIT = 500000;

  // running decode of the byte stream, and the results still owed by the block
  class tga_decode_tracker;
    tgad_pkg::phase_t phase;
    logic [4:0]       hdr_pos;
    logic [7:0]       id_len;
    logic [7:0]       cmap_type;
    logic [7:0]       img_type;
    logic [15:0]      width;
    logic [15:0]      height;
    logic [7:0]       depth;
    logic [7:0]       skip_left;
    logic [31:0]      pix_left;
    logic [1:0]       pix_pos;
    logic [23:0]      held;
    tgad_pkg::res_t   awaited[$];
    int               n_errors;
    int               n_checked;

    function new();
      phase     = tgad_pkg::PH_HEADER;
      hdr_pos   = '0;
      id_len    = '0;
      cmap_type = '0;
      img_type  = '0;
      width     = '0;
      height    = '0;
      depth     = '0;
      skip_left = '0;
      pix_left  = '0;
      pix_pos   = '0;
      held      = '0;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    // every result carries the current header fields
    function void emit(input logic [1:0] k, input logic [1:0] err,
                       input logic [7:0] r, input logic [7:0] g,
                       input logic [7:0] b, input logic [7:0] a, input logic fin);
      tgad_pkg::res_t e;
      e.kind         = k;
      e.error_code   = err;
      e.red          = r;
      e.green        = g;
      e.blue         = b;
      e.alpha        = a;
      e.image_width  = width;
      e.image_height = height;
      e.pixel_depth  = depth;
      e.has_alpha    = (depth == tgad_pkg::DEPTH_16 || depth == tgad_pkg::DEPTH_32);
      e.last         = fin;
      awaited.push_back(e);
    endfunction

    function void header_byte(input logic [7:0] v);
      logic [1:0] err;
      logic       bad;
      case (hdr_pos)
        tgad_pkg::HDR_ID_LEN:     id_len = v;
        tgad_pkg::HDR_CMAP_TYPE:  cmap_type = v;
        tgad_pkg::HDR_IMG_TYPE:   img_type = v;
        tgad_pkg::HDR_WIDTH_LO:   width[7:0] = v;
        tgad_pkg::HDR_WIDTH_HI:   width[15:8] = v;
        tgad_pkg::HDR_HEIGHT_LO:  height[7:0] = v;
        tgad_pkg::HDR_HEIGHT_HI:  height[15:8] = v;
        tgad_pkg::HDR_DEPTH:      depth = v;
        default: ;
      endcase
      if (hdr_pos != tgad_pkg::HDR_LAST) begin
        hdr_pos = hdr_pos + 5'd1;
        return;
      end
      hdr_pos = '0;
      // checks run in order of priority: type, then depth, then colour map
      bad = 1'b1;
      err = tgad_pkg::ERR_NOT_TYPE2;
      if (img_type != tgad_pkg::IMG_TYPE_TRUECOLOR) begin
        err = tgad_pkg::ERR_NOT_TYPE2;
      end else if (depth != tgad_pkg::DEPTH_16 && depth != tgad_pkg::DEPTH_24
                   && depth != tgad_pkg::DEPTH_32) begin
        err = tgad_pkg::ERR_BAD_DEPTH;
      end else if (cmap_type != 8'd0) begin
        err = tgad_pkg::ERR_COLOR_MAP;
      end else begin
        bad = 1'b0;
      end
      if (bad) begin
        phase = tgad_pkg::PH_HEADER;
        emit(tgad_pkg::KIND_HDR_BAD, err, '0, '0, '0, '0, 1'b1);
        return;
      end
      pix_left  = 32'(width) * 32'(height);
      pix_pos   = '0;
      held      = '0;
      skip_left = id_len;
      if (skip_left != 8'd0)
        phase = tgad_pkg::PH_SKIP;
      else if (pix_left != 32'd0)
        phase = tgad_pkg::PH_PIXELS;
      else
        phase = tgad_pkg::PH_HEADER;
      emit(tgad_pkg::KIND_HDR_OK, '0, '0, '0, '0, '0, pix_left == 32'd0);
    endfunction

    function void pixel_byte(input logic [7:0] v);
      logic [4:0] nbytes;
      logic [7:0] b0, b1, b2;
      logic [7:0] r, g, b, a;
      nbytes = depth[7:3];
      if (5'(pix_pos) + 5'd1 < nbytes) begin
        held    = held | (24'(v) << (8 * pix_pos));
        pix_pos = pix_pos + 2'd1;
        return;
      end
      b0 = held[7:0];
      b1 = held[15:8];
      b2 = held[23:16];
      if (nbytes == tgad_pkg::BPP_2) begin
        // 1-5-5-5, high byte last
        b1 = v;
        r  = {b1[6:2], 3'b000};
        g  = {b1[1:0], b0[7:5], 3'b000};
        b  = {b0[4:0], 3'b000};
        a  = {b1[7], 7'b0000000};
      end else if (nbytes == tgad_pkg::BPP_3) begin
        r = v;
        g = b1;
        b = b0;
        a = '0;
      end else begin
        r = b2;
        g = b1;
        b = b0;
        a = v;
      end
      pix_pos  = '0;
      held     = '0;
      pix_left = pix_left - 32'd1;
      if (pix_left == 32'd0)
        phase = tgad_pkg::PH_HEADER;
      emit(tgad_pkg::KIND_PIXEL, '0, r, g, b, a, pix_left == 32'd0);
    endfunction

    // one accepted byte of the file
    function void take_byte(input logic [7:0] v);
      case (phase)
        tgad_pkg::PH_SKIP: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 8'd0)
            phase = (pix_left != 32'd0) ? tgad_pkg::PH_PIXELS : tgad_pkg::PH_HEADER;
        end
        tgad_pkg::PH_PIXELS: begin
          if (pix_left == 32'd0) begin
            phase = tgad_pkg::PH_HEADER;
            header_byte(v);
          end else begin
            pixel_byte(v);
          end
        end
        default: begin
          phase = tgad_pkg::PH_HEADER;
          header_byte(v);
        end
      endcase
    endfunction

    task report(input string msg);
      n_errors++;
      if (n_errors <= 40)
        $display("mismatch: %s", msg);
    endtask

    task compare(input string field, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
        report($sformatf("item %0d %s: got 0x%0h, expected 0x%0h",
                         n_checked, field, got, want));
    endtask

    task check_result(input tgad_pkg::res_t got);
      tgad_pkg::res_t want;
      n_checked++;
      if (awaited.size() == 0) begin
        report($sformatf("item %0d arrived with nothing expected", n_checked));
        return;
      end
      want = awaited.pop_front();
      compare("kind",         got.kind,         want.kind);
      compare("error_code",   got.error_code,   want.error_code);
      compare("red",          got.red,          want.red);
      compare("green",        got.green,        want.green);
      compare("blue",         got.blue,         want.blue);
      compare("alpha",        got.alpha,        want.alpha);
      compare("image_width",  got.image_width,  want.image_width);
      compare("image_height", got.image_height, want.image_height);
      compare("pixel_depth",  got.pixel_depth,  want.pixel_depth);
      compare("has_alpha",    got.has_alpha,    want.has_alpha);
      compare("last",         got.last,         want.last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_error_code;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [15:0] out_image_width;
  logic [15:0] out_image_height;
  logic [7:0]  out_pixel_depth;
  logic        out_has_alpha;
  logic        out_last;

  tgad_pkg::res_t    seen;
  tga_decode_tracker tracker;
  int                idle_pct = 0;    // chance of a gap before each byte
  int                stall_pct = 0;   // chance of a stall burst on out_ready
  int                stall_left = 0;
  int                bytes_sent = 0;
  int                cycle_count = 0;

  tga_truecolor_stream_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_error_code   (out_error_code),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_pixel_depth  (out_pixel_depth),
    .out_has_alpha    (out_has_alpha),
    .out_last         (out_last)
  );

  always #10 clk = ~clk;

  assign seen = {out_kind, out_error_code, out_red, out_green, out_blue, out_alpha,
                 out_image_width, out_image_height, out_pixel_depth, out_has_alpha,
                 out_last};

  // result side: values read at the edge are the ones from before it
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(seen);
  end

  // receiver stalls come in bursts whose length is drawn at random
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(13, 1) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit depth_ok(input logic [7:0] d);
    return d == tgad_pkg::DEPTH_16 || d == tgad_pkg::DEPTH_24 || d == tgad_pkg::DEPTH_32;
  endfunction

  function automatic logic [7:0] any_depth();
    case ($urandom_range(2))
      0:       return tgad_pkg::DEPTH_16;
      1:       return tgad_pkg::DEPTH_24;
      default: return tgad_pkg::DEPTH_32;
    endcase
  endfunction

  // one byte, with an optional gap ahead of it; valid stays up until taken
  task automatic send_byte(input logic [7:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= v;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(v);
    bytes_sent++;
  endtask

  // header with random filler in the unused fields, then id field and pixels
  // when the header is one the block will take
  task automatic send_image(input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] itype, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] bpp);
    logic [7:0] hdr [0:tgad_pkg::HDR_LAST];
    logic [7:0] v;
    int         body;
    for (int i = 0; i <= tgad_pkg::HDR_LAST; i++)
      hdr[i] = 8'($urandom_range(255));
    hdr[tgad_pkg::HDR_ID_LEN]    = id_len;
    hdr[tgad_pkg::HDR_CMAP_TYPE] = cmap;
    hdr[tgad_pkg::HDR_IMG_TYPE]  = itype;
    hdr[tgad_pkg::HDR_WIDTH_LO]  = w[7:0];
    hdr[tgad_pkg::HDR_WIDTH_HI]  = w[15:8];
    hdr[tgad_pkg::HDR_HEIGHT_LO] = h[7:0];
    hdr[tgad_pkg::HDR_HEIGHT_HI] = h[15:8];
    hdr[tgad_pkg::HDR_DEPTH]     = bpp;
    for (int i = 0; i <= tgad_pkg::HDR_LAST; i++)
      send_byte(hdr[i]);
    // rejected headers go straight back to header phase, no id skip
    if (itype != tgad_pkg::IMG_TYPE_TRUECOLOR || !depth_ok(bpp) || cmap != 8'd0)
      return;
    repeat (id_len) send_byte(8'($urandom_range(255)));
    body = int'(w) * int'(h) * int'(bpp >> 3);
    repeat (body) begin
      // pixel bytes lean toward all-zero and all-one values now and then
      case ($urandom_range(9))
        0:       v = 8'h00;
        1:       v = 8'hff;
        default: v = 8'($urandom_range(255));
      endcase
      send_byte(v);
    end
  endtask

  initial begin
    int          sel;
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  itype;
    logic [7:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;

    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed files: each depth, empty images, each rejection and the
    // order in which the header checks apply
    idle_pct  = 20;
    stall_pct = 20;
    send_image(8'd0, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd2, 16'd1, tgad_pkg::DEPTH_16);
    send_image(8'd3, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd1, 16'd2, tgad_pkg::DEPTH_24);
    send_image(8'd1, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd3, 16'd1, tgad_pkg::DEPTH_32);
    // empty images: last on the header item, id field still skipped
    send_image(8'd2, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'hffff, 16'd0,
               tgad_pkg::DEPTH_32);
    send_image(8'd0, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd0, 16'hffff,
               tgad_pkg::DEPTH_24);
    // wrong type wins over every other fault
    send_image(8'd5, 8'd0, 8'd0, 16'hffff, 16'hffff, 8'hff);
    send_image(8'd0, 8'hff, 8'hff, 16'd1, 16'd1, tgad_pkg::DEPTH_24);
    // bad depth wins over a colour map
    send_image(8'd0, 8'd1, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'hffff, 16'hffff, 8'd0);
    send_image(8'd0, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, 8'd8);
    send_image(8'd0, 8'd1, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::DEPTH_24);
    send_image(8'd0, 8'hff, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, tgad_pkg::DEPTH_16);
    // longest id field
    send_image(8'hff, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd1, 16'd1, tgad_pkg::DEPTH_24);
    send_image(8'd0, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::DEPTH_16);

    // random files, mostly well formed so the pixel path gets most of the work
    while (bytes_sent < N_BYTES) begin
      if (bytes_sent > N_BYTES - 250) begin
        // closing stretch runs at full rate on both sides
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 15 * $urandom_range(3);
        stall_pct = 15 * $urandom_range(3);
      end
      sel = $urandom_range(99);
      if (sel < 62) begin
        sel = $urandom_range(99);
        if (sel < 65)
          id_len = 8'd0;
        else if (sel < 97)
          id_len = 8'($urandom_range(6, 1));
        else
          id_len = 8'($urandom_range(255, 7));
        send_image(id_len, 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, 16'($urandom_range(5, 1)),
                   16'($urandom_range(4, 1)), any_depth());
      end else if (sel < 70) begin
        // empty image, the other dimension anywhere in range
        w = 16'($urandom_range(65535));
        h = 16'd0;
        if ($urandom_range(1) == 0) begin
          h = w;
          w = 16'd0;
        end
        send_image(8'($urandom_range(4)), 8'd0, tgad_pkg::IMG_TYPE_TRUECOLOR, w, h,
                   any_depth());
      end else if (sel < 85) begin
        // one chosen rejection, the other fields random
        w = 16'($urandom_range(65535));
        h = 16'($urandom_range(65535));
        cmap = 8'($urandom_range(255));
        bpp = 8'($urandom_range(255));
        case ($urandom_range(2))
          0: begin
            do itype = 8'($urandom_range(255));
            while (itype == tgad_pkg::IMG_TYPE_TRUECOLOR);
          end
          1: begin
            itype = tgad_pkg::IMG_TYPE_TRUECOLOR;
            while (depth_ok(bpp)) bpp = 8'($urandom_range(255));
          end
          default: begin
            itype = tgad_pkg::IMG_TYPE_TRUECOLOR;
            bpp   = any_depth();
            cmap  = 8'($urandom_range(255, 1));
          end
        endcase
        send_image(8'($urandom_range(255)), cmap, itype, w, h, bpp);
      end else begin
        // noise header; a chance hit on a valid header gets a colour map
        itype = 8'($urandom_range(255));
        bpp   = 8'($urandom_range(255));
        cmap  = 8'($urandom_range(255));
        if (itype == tgad_pkg::IMG_TYPE_TRUECOLOR && depth_ok(bpp) && cmap == 8'd0)
          cmap = 8'd1;
        send_image(8'($urandom_range(255)), cmap, itype, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), bpp);
      end
    end
    in_valid <= 1'b0;

    while (tracker.awaited.size() != 0) @(posedge clk);
    // catch anything extra the block might still put out
    repeat (20) @(posedge clk);

    if (tracker.n_errors == 0 && tracker.awaited.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
